// File: sv/piecewise_linear_table_interp_assert.svh
`ifndef PIECEWISE_LINEAR_TABLE_INTERP_ASSERT_SVH
`define PIECEWISE_LINEAR_TABLE_INTERP_ASSERT_SVH

// same-cycle implication, checked outside reset
`define PLT_ASSERT_NOW(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define PLT_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: sv/plt_pkg.sv
package plt_pkg;

  localparam int MAX_POINTS = 16;
  localparam int IDX_W      = $clog2(MAX_POINTS);
  localparam int CNT_W      = IDX_W + 1;

  localparam int PER_W   = 24;
  localparam int VAL_W   = 32;
  localparam int MAG_W   = VAL_W + 1;
  localparam int ACC_W   = PER_W + MAG_W;
  localparam int STEP_W  = 6;
  localparam int PIN_W   = 5;
  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;

  localparam logic [STEP_W-1:0] MUL_STEPS = STEP_W'(PER_W);
  localparam logic [STEP_W-1:0] DIV_STEPS = STEP_W'(MAG_W);

  localparam logic CMD_LOAD  = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  localparam logic [2:0] REGION_EMPTY      = 3'd0;
  localparam logic [2:0] REGION_SINGLE     = 3'd1;
  localparam logic [2:0] REGION_CLAMP_LOW  = 3'd2;
  localparam logic [2:0] REGION_CLAMP_HIGH = 3'd3;
  localparam logic [2:0] REGION_INTERP     = 3'd4;
  localparam logic [2:0] REGION_FALLBACK   = 3'd5;

  localparam logic [PADDR_W-1:0] ADDR_POINTS_IN_USE = '0;

  // breakpoint write broadcast to the cells
  typedef struct packed {
    logic                    en;
    logic [IDX_W-1:0]        idx;
    logic [PER_W-1:0]        period;
    logic signed [VAL_W-1:0] value;
  } plt_wr_t;

  // search token passed along the cell row
  typedef struct packed {
    logic                    vld;
    logic [PER_W-1:0]        per;
    logic                    hit;
    logic [IDX_W-1:0]        seg;
    logic [PER_W-1:0]        t0;
    logic signed [VAL_W-1:0] s0;
    logic [PER_W-1:0]        t1;
    logic signed [VAL_W-1:0] s1;
    logic [PER_W-1:0]        first_t;
    logic signed [VAL_W-1:0] first_s;
    logic [PER_W-1:0]        last_t;
    logic signed [VAL_W-1:0] last_s;
  } plt_tok_t;

endpackage

// File: sv/plt_in_if.sv
interface plt_in_if;
  import plt_pkg::*;
  logic                    valid;
  logic                    ready;
  logic                    command;
  logic [3:0]              point_index;
  logic [PER_W-1:0]        period;
  logic signed [VAL_W-1:0] spectral_value;

  modport source (output valid, command, point_index, period, spectral_value, input ready);
  modport sink (input valid, command, point_index, period, spectral_value, output ready);
endinterface

// File: sv/plt_out_if.sv
interface plt_out_if;
  import plt_pkg::*;
  logic                    valid;
  logic                    ready;
  logic signed [VAL_W-1:0] interpolated_value;
  logic [2:0]              region;
  logic [3:0]              segment;

  modport source (output valid, interpolated_value, region, segment, input ready);
  modport sink (input valid, interpolated_value, region, segment, output ready);
endinterface

// File: sv/plt_cell.sv
module plt_cell
  import plt_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic [IDX_W-1:0] my_idx,
  input  logic [CNT_W-1:0] n_eff,
  input  plt_wr_t          wr,
  input  plt_tok_t         tok_i,
  output plt_tok_t         tok_o
);

  logic [PER_W-1:0]        period_r;
  logic signed [VAL_W-1:0] value_r;
  plt_tok_t                tok_r;
  plt_tok_t                tok_nxt;
  logic                    in_use;
  logic                    is_last;

  assign in_use  = {1'b0, my_idx} < n_eff;
  assign is_last = {1'b0, my_idx} == (n_eff - CNT_W'(1));

  always_comb begin
    tok_nxt = tok_i;
    if (tok_i.vld && in_use) begin
      if (my_idx == '0) begin
        tok_nxt.first_t = period_r;
        tok_nxt.first_s = value_r;
      end
      if (is_last) begin
        tok_nxt.last_t = period_r;
        tok_nxt.last_s = value_r;
      end
      if (!tok_i.hit) begin
        if (my_idx != '0 && tok_i.per <= period_r) begin
          tok_nxt.hit = 1'b1;
          tok_nxt.seg = my_idx;
          tok_nxt.t1  = period_r;
          tok_nxt.s1  = value_r;
        end else begin
          tok_nxt.t0 = period_r;
          tok_nxt.s0 = value_r;
        end
      end
    end
  end

  // breakpoint storage, undefined until loaded
  always_ff @(posedge clk) begin
    if (wr.en && wr.idx == my_idx) begin
      period_r <= wr.period;
      value_r  <= wr.value;
    end
  end

  always_ff @(posedge clk) begin
    tok_r <= tok_nxt;
    if (!rst_n) tok_r.vld <= 1'b0;
  end

  assign tok_o = tok_r;

endmodule

// File: sv/plt_lerp.sv
module plt_lerp
  import plt_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  input  logic [PER_W-1:0]        t,
  input  logic [PER_W-1:0]        t0,
  input  logic [PER_W-1:0]        t1,
  input  logic signed [VAL_W-1:0] s0,
  input  logic signed [VAL_W-1:0] s1,
  output logic                    done,
  output logic signed [VAL_W-1:0] value
);

  typedef enum logic [1:0] {ST_IDLE, ST_MUL, ST_DIV} state_t;

  state_t                  state_r;
  logic [STEP_W-1:0]       cnt_r;
  logic [PER_W-1:0]        a_r;
  logic [PER_W-1:0]        dt_r;
  logic [MAG_W-1:0]        m_r;
  logic                    neg_r;
  logic signed [VAL_W-1:0] s0_r;
  logic [ACC_W-1:0]        acc_r;
  logic [PER_W-1:0]        rem_r;
  logic [MAG_W-1:0]        dq_r;
  logic                    done_r;
  logic signed [VAL_W-1:0] value_r;

  logic signed [MAG_W-1:0] ds;
  logic [ACC_W-1:0]        acc_nxt;
  logic [PER_W:0]          trial;
  logic                    qbit;
  logic [PER_W-1:0]        rem_nxt;
  logic [MAG_W-1:0]        dq_nxt;
  logic signed [MAG_W:0]   q_signed;
  logic signed [MAG_W:0]   sum;

  assign ds = MAG_W'(s1) - MAG_W'(s0);

  // shift-add, multiplier bits msb first
  assign acc_nxt = {acc_r[ACC_W-2:0], 1'b0} + (a_r[PER_W-1] ? ACC_W'(m_r) : '0);

  // restoring division, one quotient bit a step
  assign trial   = {rem_r, dq_r[MAG_W-1]};
  assign qbit    = trial >= {1'b0, dt_r};
  assign rem_nxt = qbit ? PER_W'(trial - {1'b0, dt_r}) : trial[PER_W-1:0];
  assign dq_nxt  = {dq_r[MAG_W-2:0], qbit};

  assign q_signed = neg_r ? -$signed({1'b0, dq_nxt}) : $signed({1'b0, dq_nxt});
  assign sum      = $signed((MAG_W+1)'(s0_r)) + q_signed;

  always_ff @(posedge clk) begin
    done_r <= 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          a_r     <= t - t0;
          dt_r    <= t1 - t0;
          neg_r   <= ds[MAG_W-1];
          m_r     <= ds[MAG_W-1] ? MAG_W'(-ds) : MAG_W'(ds);
          s0_r    <= s0;
          acc_r   <= '0;
          cnt_r   <= '0;
          state_r <= ST_MUL;
        end
      end
      ST_MUL: begin
        acc_r <= acc_nxt;
        a_r   <= {a_r[PER_W-2:0], 1'b0};
        cnt_r <= cnt_r + STEP_W'(1);
        if (cnt_r == MUL_STEPS - STEP_W'(1)) begin
          rem_r   <= acc_nxt[ACC_W-1:MAG_W];
          dq_r    <= acc_nxt[MAG_W-1:0];
          cnt_r   <= '0;
          state_r <= ST_DIV;
        end
      end
      ST_DIV: begin
        rem_r <= rem_nxt;
        dq_r  <= dq_nxt;
        cnt_r <= cnt_r + STEP_W'(1);
        if (cnt_r == DIV_STEPS - STEP_W'(1)) begin
          value_r <= sum[VAL_W-1:0];
          done_r  <= 1'b1;
          state_r <= ST_IDLE;
        end
      end
      default: state_r <= ST_IDLE;
    endcase
    if (!rst_n) begin
      state_r <= ST_IDLE;
      done_r  <= 1'b0;
    end
  end

  assign done  = done_r;
  assign value = value_r;

endmodule

// File: sv/piecewise_linear_table_interp.sv
// Piecewise-linear table lookup. Up to MAX_POINTS breakpoints (period in
// unsigned Q8.16, value in signed Q16.16) live in a row of cells, one
// breakpoint per cell. A load beat writes one cell and gives no result. A
// query beat launches a token that walks the row one cell a cycle,
// collecting the end points and the first breakpoint at or above the
// query. Empty, single-point, clamped and fallback queries then go through
// the finish state into the output register. Interpolated queries first
// pass through a shift-add multiplier and then a restoring divider before
// reaching the finish state, like the other queries. One item is
// in flight at a time; a result waits in the output register, so the next
// beat is accepted while it is still unclaimed. points_in_use is written
// through the APB port at byte address 0 and must only change while idle.
module piecewise_linear_table_interp
  import plt_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  plt_in_if.sink             in_ch,
  plt_out_if.source          out_ch,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready
);

  typedef enum logic [1:0] {ST_IDLE, ST_SEARCH, ST_LERP, ST_FINISH} state_t;

  state_t                  state_r;
  logic [PIN_W-1:0]        pin_r;
  logic [CNT_W-1:0]        n_eff;

  // result staging and output register
  logic signed [VAL_W-1:0] res_val_r;
  logic [2:0]              res_region_r;
  logic [IDX_W-1:0]        res_seg_r;
  logic                    out_vld_r;
  logic signed [VAL_W-1:0] out_val_r;
  logic [2:0]              out_region_r;
  logic [3:0]              out_seg_r;

  logic                    in_acc;
  logic                    out_load;
  logic                    lerp_start;
  logic                    lerp_done;
  logic signed [VAL_W-1:0] lerp_value;
  plt_wr_t                 wr;
  plt_tok_t                tok_head;
  plt_tok_t                tok_chain [MAX_POINTS];
  plt_tok_t                tok_tail;

  // config port, single register
  assign pready = 1'b1;
  assign prdata = (paddr == ADDR_POINTS_IN_USE) ? PDATA_W'(pin_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pin_r <= '0;
    end else if (psel && penable && pwrite && pready && paddr == ADDR_POINTS_IN_USE) begin
      pin_r <= pwdata[PIN_W-1:0];
    end
  end

  // counts above the table depth read as the full table
  assign n_eff = (32'(pin_r) > 32'(MAX_POINTS)) ? CNT_W'(MAX_POINTS) : CNT_W'(pin_r);

  assign in_ch.ready = (state_r == ST_IDLE);
  assign in_acc      = in_ch.valid && in_ch.ready;

  // load beats broadcast straight into the cells
  assign wr.en     = in_acc && in_ch.command == CMD_LOAD
                     && 32'(in_ch.point_index) < 32'(MAX_POINTS);
  assign wr.idx    = IDX_W'(in_ch.point_index);
  assign wr.period = in_ch.period;
  assign wr.value  = in_ch.spectral_value;

  always_comb begin
    tok_head     = '0;
    tok_head.vld = in_acc && in_ch.command == CMD_QUERY;
    tok_head.per = in_ch.period;
  end

  for (genvar g = 0; g < MAX_POINTS; g++) begin : g_cell
    plt_cell u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .my_idx (IDX_W'(g)),
      .n_eff  (n_eff),
      .wr     (wr),
      .tok_i  ((g == 0) ? tok_head : tok_chain[(g == 0) ? 0 : g - 1]),
      .tok_o  (tok_chain[g])
    );
  end

  assign tok_tail   = tok_chain[MAX_POINTS-1];
  assign lerp_start = state_r == ST_SEARCH && tok_tail.vld && n_eff > CNT_W'(1)
                      && tok_tail.per > tok_tail.first_t
                      && tok_tail.per < tok_tail.last_t && tok_tail.hit;

  plt_lerp u_lerp (
    .clk   (clk),
    .rst_n (rst_n),
    .start (lerp_start),
    .t     (tok_tail.per),
    .t0    (tok_tail.t0),
    .t1    (tok_tail.t1),
    .s0    (tok_tail.s0),
    .s1    (tok_tail.s1),
    .done  (lerp_done),
    .value (lerp_value)
  );

  // result may enter the output register once the old one is gone
  assign out_load = state_r == ST_FINISH && (!out_vld_r || out_ch.ready);

  always_ff @(posedge clk) begin
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc && in_ch.command == CMD_QUERY) state_r <= ST_SEARCH;
      end
      ST_SEARCH: begin
        if (tok_tail.vld) begin
          res_seg_r <= '0;
          state_r   <= ST_FINISH;
          if (n_eff == '0) begin
            res_val_r    <= '0;
            res_region_r <= REGION_EMPTY;
          end else if (n_eff == CNT_W'(1)) begin
            res_val_r    <= tok_tail.first_s;
            res_region_r <= REGION_SINGLE;
          end else if (tok_tail.per <= tok_tail.first_t) begin
            res_val_r    <= tok_tail.first_s;
            res_region_r <= REGION_CLAMP_LOW;
          end else if (tok_tail.per >= tok_tail.last_t) begin
            res_val_r    <= tok_tail.last_s;
            res_region_r <= REGION_CLAMP_HIGH;
          end else if (tok_tail.hit) begin
            res_seg_r    <= tok_tail.seg;
            res_region_r <= REGION_INTERP;
            state_r      <= ST_LERP;
          end else begin
            // unsorted table with no breakpoint above the query
            res_val_r    <= tok_tail.last_s;
            res_region_r <= REGION_FALLBACK;
          end
        end
      end
      ST_LERP: begin
        if (lerp_done) begin
          res_val_r <= lerp_value;
          state_r   <= ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (out_load) state_r <= ST_IDLE;
      end
      default: state_r <= ST_IDLE;
    endcase

    if (out_load) begin
      out_vld_r    <= 1'b1;
      out_val_r    <= res_val_r;
      out_region_r <= res_region_r;
      out_seg_r    <= 4'(res_seg_r);
    end else if (out_ch.ready) begin
      out_vld_r <= 1'b0;
    end

    if (!rst_n) begin
      state_r   <= ST_IDLE;
      out_vld_r <= 1'b0;
    end
  end

  assign out_ch.valid              = out_vld_r;
  assign out_ch.interpolated_value = out_val_r;
  assign out_ch.region             = out_region_r;
  assign out_ch.segment            = out_seg_r;

`include "piecewise_linear_table_interp_assert.svh"

  `PLT_ASSERT_NOW(a_seg_only_interp, out_vld_r && out_region_r != REGION_INTERP, out_seg_r == 4'd0, "segment set outside interpolation")
  `PLT_ASSERT_NOW(a_tok_in_search, tok_tail.vld, state_r == ST_SEARCH, "search token out of step with control")
  `PLT_ASSERT_NEXT(a_lerp_to_finish, state_r == ST_LERP && lerp_done, state_r == ST_FINISH, "divider result not taken")

endmodule
